// ===== rtl/dshot_erpm_telemetry_decoder_top_assert.svh =====
// Assertion macros used by the decoder top module.
// Both expect signals named clk and rst in the module that uses them.
`ifndef DSHOT_ERPM_TELEMETRY_DECODER_TOP_ASSERT_SVH
`define DSHOT_ERPM_TELEMETRY_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSHOT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSHOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dshot_pkg.sv =====
package dshot_pkg;

  localparam int DurWidth    = 15;
  localparam int PeriodWidth = 15;
  localparam int RunWidth    = 5;
  localparam int CountWidth  = 5;
  localparam int StepWidth   = 3;
  localparam int FrameBits   = 21;
  localparam int StatusWidth = 3;
  localparam int ErpmWidth   = 16;

  localparam int NumWidth   = ((DurWidth > PeriodWidth) ? DurWidth : PeriodWidth) + 2;
  localparam int DenWidth   = PeriodWidth + 1;
  localparam int TrialWidth = ((NumWidth > DenWidth + RunWidth) ? NumWidth
                                                               : DenWidth + RunWidth) + 1;

  localparam int InTdataWidth  = ((2 * DurWidth + 2 + 7) / 8) * 8;
  localparam int OutTdataWidth = ((StatusWidth + ErpmWidth + 7) / 8) * 8;

  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(213);
  localparam logic [CountWidth-1:0]  CountMax    = '1;
  localparam logic [CountWidth-1:0]  FrameCount  = CountWidth'(FrameBits);
  localparam logic [CountWidth-1:0]  PadFrom     = CountWidth'(FrameBits - 4);
  localparam logic [StepWidth-1:0]   StepFirst   = StepWidth'(RunWidth);

  typedef enum logic [StatusWidth-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_FRAME  = 3'd4
  } status_t;

  typedef struct packed {
    logic                start;
    logic [DurWidth-1:0] duration;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [RunWidth-1:0] run_len;
  } div_res_t;

  typedef struct packed {
    status_t              status;
    logic [ErpmWidth-1:0] erpm_period;
  } result_t;

  // Inverse of the 4b/5b GCR code; codes that are not in the code give 0.
  function automatic logic [3:0] gcr_inverse(input logic [4:0] code);
    logic [3:0] nib;
    case (code)
      5'h09:   nib = 4'h9;
      5'h0A:   nib = 4'hA;
      5'h0B:   nib = 4'hB;
      5'h0D:   nib = 4'hD;
      5'h0E:   nib = 4'hE;
      5'h0F:   nib = 4'hF;
      5'h12:   nib = 4'h2;
      5'h13:   nib = 4'h3;
      5'h15:   nib = 4'h5;
      5'h16:   nib = 4'h6;
      5'h17:   nib = 4'h7;
      5'h1A:   nib = 4'h8;
      5'h1B:   nib = 4'h1;
      5'h1D:   nib = 4'h4;
      5'h1E:   nib = 4'hC;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

  // Shifts a run of n equal bits into the frame register; long runs fill it.
  function automatic logic [FrameBits-1:0] shift_run(input logic [FrameBits-1:0] bits,
                                                     input logic [RunWidth-1:0]  n,
                                                     input logic                 fill);
    logic [FrameBits-1:0] ones;
    logic [FrameBits-1:0] res;
    ones = (FrameBits'(1) << n) - FrameBits'(1);
    if (n >= RunWidth'(FrameBits)) begin
      res = fill ? '1 : '0;
    end else begin
      res = (bits << n) | (fill ? ones : '0);
    end
    return res;
  endfunction

  function automatic logic [CountWidth-1:0] count_add(input logic [CountWidth-1:0] count,
                                                      input logic [RunWidth-1:0]   n);
    logic [CountWidth:0] sum;
    sum = {1'b0, count} + (CountWidth + 1)'(n);
    return (sum > {1'b0, CountMax}) ? CountMax : sum[CountWidth-1:0];
  endfunction

  // Unscrambles a full frame, checks its checksum and extracts the period.
  function automatic result_t decode_frame(input logic [FrameBits-1:0] bits);
    logic [FrameBits-1:0] x;
    logic [3:0]           crc;
    logic [11:0]          v;
    logic [3:0]           chk;
    result_t              r;
    x   = bits ^ (bits >> 1);
    crc = gcr_inverse(x[4:0]);
    v   = {gcr_inverse(x[19:15]), gcr_inverse(x[14:10]), gcr_inverse(x[9:5])};
    chk = ~(v[3:0] ^ v[7:4] ^ v[11:8]);
    r.status      = ST_BAD_FRAME;
    r.erpm_period = '0;
    if ((chk == crc) && v[8]) begin
      r.status      = ST_OK;
      r.erpm_period = ErpmWidth'({7'b0, v[8:0]} << v[11:9]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/dshot_run_div.sv =====
// Rounding divider, one compare and subtract per cycle.
// The first step only checks whether the quotient reaches 32, which is
// reported as the saturated run length of 31.
module dshot_run_div import dshot_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  div_req_t               req,
  input  logic [PeriodWidth-1:0] period,
  output div_res_t               res
);

  logic                   busy;
  logic                   done;
  logic                   sat;
  logic [StepWidth-1:0]   step;
  logic [NumWidth-1:0]    rem;
  logic [DenWidth-1:0]    den;
  logic [RunWidth-1:0]    quo;
  logic [PeriodWidth-1:0] period_eff;
  logic [TrialWidth-1:0]  trial;
  logic                   fits;

  always_comb begin
    period_eff = (period == '0) ? PeriodWidth'(1) : period;
    trial      = TrialWidth'(rem) - (TrialWidth'(den) << step);
    fits       = ~trial[TrialWidth-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= StepFirst;
        rem  <= (NumWidth'(req.duration) << 1) + NumWidth'(period_eff);
        den  <= {period_eff, 1'b0};
        quo  <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        if (step == StepFirst) begin
          if (fits) begin
            sat  <= 1'b1;
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step - StepWidth'(1);
          end
        end else begin
          if (fits) begin
            rem <= trial[NumWidth-1:0];
          end
          quo <= {quo[RunWidth-2:0], fits};
          if (step == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step - StepWidth'(1);
          end
        end
      end
    end
  end

  assign res.done    = done;
  assign res.run_len = sat ? '1 : quo;

endmodule

// ===== rtl/dshot_erpm_telemetry_decoder_top.sv =====
// Channel   Direction  Handshake             Contents
// cfg       in         cfg_we                cfg_wdata: bit_period_ticks
// s_*       in         s_tvalid / s_tready   one telemetry symbol, tlast = last_symbol
// m_*       out        m_tvalid / m_tready   one frame result (status, erpm_period)
//
// A symbol that is not the last of its frame holds the input off after it is accepted
// until the six-step serial divider has run once for each half of the symbol.
// A run of 32 bits or more ends its division at the first step. After the last symbol
// the sequencer goes on through padding, decoding and loading the output register; an
// empty frame goes straight to loading the output register. The block holds off new
// items while the output register is still full and a finished result is waiting.
// Reset is synchronous.
`include "dshot_erpm_telemetry_decoder_top_assert.svh"

module dshot_erpm_telemetry_decoder_top import dshot_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [PeriodWidth-1:0]   cfg_wdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // low_level, low_duration, high_level, high_duration
  input  logic [InTdataWidth-1:0]  s_tdata,
  // frame_empty
  input  logic                     s_tuser,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status, erpm_period, zero padding
  output logic [OutTdataWidth-1:0] m_tdata
);

  // One-hot sequencer: each symbol runs the divider for its low half and then
  // for its high half; the last symbol of a frame goes on to the frame checks.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV_LO = 6'b000010,
    S_DIV_HI = 6'b000100,
    S_PAD    = 6'b001000,
    S_DECODE = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t                   state;
  logic [PeriodWidth-1:0]   bit_period_ticks;
  logic [FrameBits-1:0]     bit_shift_reg;
  logic [CountWidth-1:0]    bit_count;
  logic                     at_frame_start;
  logic                     start_level_bad;
  logic                     hi_level;
  logic [DurWidth-1:0]      hi_duration;
  logic                     last_symbol;
  result_t                  result;
  logic                     out_valid;
  logic [OutTdataWidth-1:0] out_data;

  logic                     in_accept;
  logic                     in_low_level;
  logic [DurWidth-1:0]      in_low_duration;
  logic                     in_high_level;
  logic [DurWidth-1:0]      in_high_duration;
  logic                     out_load;
  logic [StatusWidth-1:0]   out_status;
  logic [ErpmWidth-1:0]     out_period;
  div_req_t                 div_req;
  div_res_t                 div_res;
  logic                     in_division;
  logic                     frame_fresh;
  logic                     out_ok;
  logic                     out_failed;

  assign in_low_level     = s_tdata[0];
  assign in_low_duration  = s_tdata[DurWidth:1];
  assign in_high_level    = s_tdata[DurWidth+1];
  assign in_high_duration = s_tdata[2*DurWidth+1:DurWidth+2];

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == S_FIN) && (!out_valid || m_tready);

  // The divider starts on the low half as the symbol is taken, and on the high
  // half as soon as the low half has been shifted in.
  assign div_req.start    = (in_accept && !s_tuser) || ((state == S_DIV_LO) && div_res.done);
  assign div_req.duration = (state == S_IDLE) ? in_low_duration : hi_duration;

  dshot_run_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .period (bit_period_ticks),
    .res    (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      bit_period_ticks <= PeriodReset;
      bit_shift_reg    <= '0;
      bit_count        <= '0;
      at_frame_start   <= 1'b1;
      start_level_bad  <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        bit_period_ticks <= cfg_wdata;
      end
      // A new result may replace the one being taken in the same cycle.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (s_tuser) begin
              // An empty frame reports at once and drops whatever was collected.
              result.status      <= ST_EMPTY;
              result.erpm_period <= '0;
              state              <= S_FIN;
            end else begin
              hi_level    <= in_high_level;
              hi_duration <= in_high_duration;
              last_symbol <= s_tlast;
              if (at_frame_start) begin
                start_level_bad <= in_low_level;
                at_frame_start  <= 1'b0;
              end
              state <= S_DIV_LO;
            end
          end
        end
        S_DIV_LO: begin
          if (div_res.done) begin
            bit_shift_reg <= shift_run(bit_shift_reg, div_res.run_len, 1'b0);
            bit_count     <= count_add(bit_count, div_res.run_len);
            state         <= S_DIV_HI;
          end
        end
        S_DIV_HI: begin
          if (div_res.done) begin
            bit_shift_reg <= shift_run(bit_shift_reg, div_res.run_len, 1'b1);
            bit_count     <= count_add(bit_count, div_res.run_len);
            state         <= last_symbol ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          // A frame one to three bits short whose line ends high lost its trailing ones.
          if (!start_level_bad && (bit_count > PadFrom) && (bit_count < FrameCount) &&
              hi_level) begin
            bit_shift_reg <= shift_run(bit_shift_reg, RunWidth'(FrameCount - bit_count), 1'b1);
            bit_count     <= FrameCount;
          end
          state <= S_DECODE;
        end
        S_DECODE: begin
          if (start_level_bad) begin
            result.status      <= ST_BAD_START;
            result.erpm_period <= '0;
          end else if (bit_count != FrameCount) begin
            result.status      <= ST_BAD_LENGTH;
            result.erpm_period <= '0;
          end else begin
            result <= decode_frame(bit_shift_reg);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_data        <= OutTdataWidth'({result.erpm_period, result.status});
            bit_shift_reg   <= '0;
            bit_count       <= '0;
            at_frame_start  <= 1'b1;
            start_level_bad <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;
  assign out_status = out_data[StatusWidth-1:0];
  assign out_period = out_data[StatusWidth+ErpmWidth-1:StatusWidth];

  assign in_division = (state == S_DIV_LO) || (state == S_DIV_HI);
  assign frame_fresh = (bit_count == '0) && at_frame_start && !start_level_bad;
  assign out_ok      = out_valid && (out_status == ST_OK);
  assign out_failed  = out_valid && (out_status != ST_OK);

  // The divider only reports while the sequencer waits for it.
  `DSHOT_ASSERT_SAME(a_div_done_in_div, div_res.done, in_division, "stray divider result")
  // Every delivered result leaves a fresh frame behind.
  `DSHOT_ASSERT_NEXT(a_frame_cleared, out_load, frame_fresh, "frame not cleared after a result")
  // A good eRPM frame has its mantissa top bit set, so its period is never zero.
  `DSHOT_ASSERT_SAME(a_ok_has_period, out_ok, out_period != '0, "good frame with zero period")
  // Every failed frame reports a zero period.
  `DSHOT_ASSERT_SAME(a_fail_no_period, out_failed, out_period == '0, "failed frame with a period")

endmodule
